/* hw/rtl/piecewise_linear_interpolator_top_defines.svh */
// Assertion macros used by the port-level checker of the piecewise-linear interpolator.
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PLI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("piecewise linear interpolator: check failed");

// The consequent must hold in the cycle after the antecedent.
`define PLI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("piecewise linear interpolator: check failed");

`endif

/* hw/rtl/plin_pkg.sv */
// Shared types, constants and helper functions of the piecewise-linear interpolator.
package plin_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W     = 32;
    localparam int PROD_W     = 2 * DATA_W;
    localparam int CHUNK_W    = 16;
    localparam int MUL_STEPS  = DATA_W / CHUNK_W;
    localparam int IDX_IN_W   = 3;
    localparam int SEG_W      = 3;
    localparam int CFG_W      = 4;
    localparam int DIFF_W     = DATA_W + 1;
    localparam int QFIT_W     = 34;
    localparam int SUM_W      = QFIT_W + 2;

    // Table size and register reset values.
    localparam int              MAX_POINTS_DEF = 8;
    localparam int              MIN_POINTS     = 2;
    localparam logic [CFG_W-1:0] PTS_RESET     = 4'd2;

    // Command codes of the input channel.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Saturation limits of a Q16.16 result.
    localparam logic [DATA_W-1:0] SAT_MAX = 32'h7FFF_FFFF;
    localparam logic [DATA_W-1:0] SAT_MIN = 32'h8000_0000;

    // Operands handed to the multiply-divide unit, all magnitudes.
    typedef struct packed {
        logic [DATA_W-1:0] mag_dy;
        logic [DATA_W-1:0] mag_dt;
        logic [DATA_W-1:0] mag_dx;
    } md_req_t;

    // Magnitude of a 33-bit difference of two 32-bit values; it always fits in 32 bits.
    function automatic logic [DATA_W-1:0] mag33(input logic signed [DIFF_W-1:0] v);
        logic [DIFF_W-1:0] neg_v;
        neg_v = -v;
        return v[DIFF_W-1] ? neg_v[DATA_W-1:0] : v[DATA_W-1:0];
    endfunction

endpackage

/* hw/rtl/plin_ram.sv */
// Generic single-write, single-read RAM with a registered read port.
module plin_ram #(
    parameter int WIDTH = 2 * plin_pkg::DATA_W,
    parameter int DEPTH = plin_pkg::MAX_POINTS_DEF,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/plin_muldiv.sv */
// Iterative unit that forms |dy|*|dt| in 16-bit chunks and divides it by |dx| one bit a cycle.
module plin_muldiv (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  plin_pkg::md_req_t             req,
    output logic                          done,
    output logic [plin_pkg::PROD_W-1:0]   quotient
);

    localparam int CNT_W  = $clog2(plin_pkg::PROD_W);
    localparam int PART_W = plin_pkg::DATA_W + plin_pkg::CHUNK_W;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV
    } md_state_t;

    md_state_t                      state_reg, state_next;
    logic [CNT_W-1:0]               cnt_reg, cnt_next;
    logic [plin_pkg::DATA_W-1:0]    a_reg, a_next;
    logic [plin_pkg::DATA_W-1:0]    b_reg, b_next;
    logic [plin_pkg::DATA_W-1:0]    d_reg, d_next;
    logic [plin_pkg::PROD_W-1:0]    acc_reg, acc_next;
    logic [plin_pkg::DATA_W-1:0]    rem_reg, rem_next;
    logic                           done_reg, done_next;

    logic [PART_W-1:0]              part;
    logic [plin_pkg::DATA_W:0]      rem_sh;
    logic [plin_pkg::DATA_W:0]      rem_sub;
    logic                           rem_ge;

    // One partial product of the multiplicand and the top chunk of the multiplier.
    assign part = a_reg * b_reg[plin_pkg::DATA_W-1 -: plin_pkg::CHUNK_W];

    // One restoring division step: shift in the next dividend bit and try a subtract.
    assign rem_sh  = {rem_reg, acc_reg[plin_pkg::PROD_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, d_reg};
    assign rem_sub = rem_sh - {1'b0, d_reg};

    // Sequencer: multiply phase, then divide phase, with the quotient built in place.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        a_next     = a_reg;
        b_next     = b_reg;
        d_next     = d_reg;
        acc_next   = acc_reg;
        rem_next   = rem_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            MD_IDLE: begin
                if (start) begin
                    a_next     = req.mag_dy;
                    b_next     = req.mag_dt;
                    d_next     = req.mag_dx;
                    acc_next   = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = MD_MUL;
                end
            end
            MD_MUL: begin
                acc_next = (acc_reg << plin_pkg::CHUNK_W) + plin_pkg::PROD_W'(part);
                b_next   = b_reg << plin_pkg::CHUNK_W;
                if (cnt_reg == CNT_W'(plin_pkg::MUL_STEPS - 1)) begin
                    cnt_next   = '0;
                    state_next = MD_DIV;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            MD_DIV: begin
                rem_next = rem_ge ? rem_sub[plin_pkg::DATA_W-1:0]
                                  : rem_sh[plin_pkg::DATA_W-1:0];
                acc_next = {acc_reg[plin_pkg::PROD_W-2:0], rem_ge};
                if (cnt_reg == CNT_W'(plin_pkg::PROD_W - 1)) begin
                    done_next  = 1'b1;
                    state_next = MD_IDLE;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default: begin
                state_next = MD_IDLE;
            end
        endcase
    end

    // State and working registers.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
        d_reg   <= d_next;
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        if (!aresetn) begin
            state_reg <= MD_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

/* hw/rtl/piecewise_linear_interpolator_top.sv */
// Top level of the piecewise-linear table interpolator: table, segment search and result.
//
// Input channel (s_*): a transfer with s_cmd = load writes one breakpoint (abscissa and
// Q16.16 ordinate) at s_entry_index and gives no result. A transfer
// with s_cmd = query interpolates at s_query_point and gives one result on m_*.
// The configuration write port sets how many breakpoints a query uses (2 up to the table
// size); write it only while no query is in flight.
// A query runs through a sequencer that reads the table one entry a cycle: the segment
// search, the segment fetch, the multiply-divide unit (two 32x16 partial products, a
// 64-step bit-serial divide and the hand-back of the quotient), and loading the output
// register. A query whose segment has equal abscissas skips the divide. s_ready is low
// while a query is in flight, so one query is at work at a time, and the next item is
// taken at the earliest once the result has been loaded into the output register.
// The result waits in an output register until m_ready takes it; while it waits, new items
// are still accepted, and a later query holds its finished result until that register frees.
// Reset clears the control state and sets the breakpoint count to 2; the table contents
// are not cleared and must be loaded before they are queried.
module piecewise_linear_interpolator_top #(
    parameter int MAX_POINTS = plin_pkg::MAX_POINTS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [plin_pkg::CFG_W-1:0]           cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_cmd,
    input  logic [plin_pkg::IDX_IN_W-1:0]        s_entry_index,
    input  logic signed [plin_pkg::DATA_W-1:0]   s_abscissa,
    input  logic signed [plin_pkg::DATA_W-1:0]   s_ordinate,
    input  logic signed [plin_pkg::DATA_W-1:0]   s_query_point,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [plin_pkg::DATA_W-1:0]   m_interpolated,
    output logic [plin_pkg::SEG_W-1:0]           m_segment_low,
    output logic                                 m_saturated,
    output logic                                 m_zero_span
);

    localparam int IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CNT_W   = $clog2(MAX_POINTS + 1);
    localparam int ENTRY_W = 2 * plin_pkg::DATA_W;
    localparam int DW      = plin_pkg::DATA_W;
    localparam int XW      = plin_pkg::DIFF_W;

    typedef enum logic [3:0] {
        S_IDLE,
        S_X0,
        S_X1,
        S_XL,
        S_SCAN,
        S_LO,
        S_HI,
        S_CHK,
        S_MD,
        S_OUT
    } state_t;

    // Configuration register.
    logic [plin_pkg::CFG_W-1:0] points_used_reg;

    // Sequencer and working registers.
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       n_reg, n_next;
    logic signed [DW-1:0]   t_reg, t_next;
    logic signed [DW-1:0]   x0_reg, x0_next;
    logic                   asc_reg, asc_next;
    logic [IDX_W-1:0]       scan_reg, scan_next;
    logic [IDX_W-1:0]       seg_reg, seg_next;
    logic signed [DW-1:0]   x1_reg, x1_next;
    logic signed [DW-1:0]   y1_reg, y1_next;
    logic signed [XW-1:0]   dx_reg, dx_next;
    logic signed [XW-1:0]   dy_reg, dy_next;
    logic signed [XW-1:0]   dt_reg, dt_next;
    logic [DW-1:0]          res_val_reg, res_val_next;
    logic                   res_sat_reg, res_sat_next;
    logic                   res_zs_reg, res_zs_next;

    // Output register.
    logic                   m_valid_reg, m_valid_next;
    logic [DW-1:0]          m_val_reg, m_val_next;
    logic [IDX_W-1:0]       m_seg_reg, m_seg_next;
    logic                   m_sat_reg, m_sat_next;
    logic                   m_zs_reg, m_zs_next;

    // Table memory and multiply-divide unit.
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [IDX_W-1:0]       ram_raddr;
    logic [ENTRY_W-1:0]     ram_rdata;
    logic signed [DW-1:0]   rd_x;
    logic signed [DW-1:0]   rd_y;
    logic                   md_start;
    plin_pkg::md_req_t      md_req;
    logic                   md_done;
    logic [plin_pkg::PROD_W-1:0] md_quo;

    // Derived values.
    logic [CNT_W-1:0]       n_sel;
    logic [IDX_W-1:0]       last_idx;
    logic                   neg;
    logic [plin_pkg::SUM_W-1:0] sum;

    // The breakpoint count register is written directly from the port.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            points_used_reg <= plin_pkg::PTS_RESET;
        end else if (cfg_wr_en) begin
            points_used_reg <= cfg_wr_data;
        end
    end

    // Clamp the configured count to the range from 2 up to the table size.
    always_comb begin
        if (int'(points_used_reg) < plin_pkg::MIN_POINTS) begin
            n_sel = CNT_W'(plin_pkg::MIN_POINTS);
        end else if (int'(points_used_reg) > MAX_POINTS) begin
            n_sel = CNT_W'(MAX_POINTS);
        end else begin
            n_sel = CNT_W'(points_used_reg);
        end
    end

    assign last_idx  = IDX_W'(n_reg - CNT_W'(1));
    assign rd_x      = ram_rdata[ENTRY_W-1 -: DW];
    assign rd_y      = ram_rdata[DW-1:0];
    assign ram_waddr = IDX_W'(s_entry_index);

    // Operands for the multiply-divide unit.
    assign md_req.mag_dy = plin_pkg::mag33(dy_reg);
    assign md_req.mag_dt = plin_pkg::mag33(dt_reg);
    assign md_req.mag_dx = plin_pkg::mag33(dx_reg);

    // Sign of the quotient and the unsaturated sum with the lower ordinate.
    assign neg = dy_reg[XW-1] ^ dt_reg[XW-1] ^ dx_reg[XW-1];
    always_comb begin
        if (neg) begin
            sum = plin_pkg::SUM_W'(y1_reg) - {2'b00, md_quo[plin_pkg::QFIT_W-1:0]};
        end else begin
            sum = plin_pkg::SUM_W'(y1_reg) + {2'b00, md_quo[plin_pkg::QFIT_W-1:0]};
        end
    end

    plin_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_POINTS)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({s_abscissa, s_ordinate}),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    plin_muldiv u_muldiv (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (md_start),
        .req      (md_req),
        .done     (md_done),
        .quotient (md_quo)
    );

    // Sequencer: table writes, segment search, segment fetch, differences, divide and result hand-off.
    always_comb begin
        logic             hit;
        logic [IDX_W-1:0] seg_pick;

        hit          = 1'b0;
        seg_pick     = '0;
        state_next   = state_reg;
        n_next       = n_reg;
        t_next       = t_reg;
        x0_next      = x0_reg;
        asc_next     = asc_reg;
        scan_next    = scan_reg;
        seg_next     = seg_reg;
        x1_next      = x1_reg;
        y1_next      = y1_reg;
        dx_next      = dx_reg;
        dy_next      = dy_reg;
        dt_next      = dt_reg;
        res_val_next = res_val_reg;
        res_sat_next = res_sat_reg;
        res_zs_next  = res_zs_reg;
        m_val_next   = m_val_reg;
        m_seg_next   = m_seg_reg;
        m_sat_next   = m_sat_reg;
        m_zs_next    = m_zs_reg;
        ram_we       = 1'b0;
        ram_raddr    = '0;
        md_start     = 1'b0;

        // A waiting result leaves when the receiver takes it.
        m_valid_next = m_valid_reg & ~m_ready;

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    if (s_cmd == plin_pkg::CMD_QUERY) begin
                        n_next     = n_sel;
                        t_next     = s_query_point;
                        ram_raddr  = '0;
                        state_next = S_X0;
                    end else if (int'(s_entry_index) < MAX_POINTS) begin
                        ram_we = 1'b1;
                    end
                end
            end
            S_X0: begin
                x0_next    = rd_x;
                ram_raddr  = IDX_W'(1);
                state_next = S_X1;
            end
            S_X1: begin
                // Direction of the table, then the check below its first abscissa.
                asc_next = rd_x > x0_reg;
                hit      = (rd_x > x0_reg) ? (t_reg <= x0_reg) : (t_reg >= x0_reg);
                if (hit) begin
                    seg_next   = '0;
                    ram_raddr  = '0;
                    state_next = S_LO;
                end else begin
                    ram_raddr  = last_idx;
                    state_next = S_XL;
                end
            end
            S_XL: begin
                // Beyond the last breakpoint: extrapolate along the end segment.
                hit = asc_reg ? (t_reg >= rd_x) : (t_reg <= rd_x);
                if (hit) begin
                    seg_pick   = last_idx - 1'b1;
                    seg_next   = seg_pick;
                    ram_raddr  = seg_pick;
                    state_next = S_LO;
                end else begin
                    scan_next  = IDX_W'(1);
                    ram_raddr  = IDX_W'(1);
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                // First breakpoint past the query point closes the segment.
                hit = asc_reg ? (t_reg < rd_x) : (t_reg > rd_x);
                if (hit || (scan_reg == last_idx)) begin
                    seg_pick   = hit ? (scan_reg - 1'b1) : (last_idx - 1'b1);
                    seg_next   = seg_pick;
                    ram_raddr  = seg_pick;
                    state_next = S_LO;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    ram_raddr  = scan_reg + 1'b1;
                end
            end
            S_LO: begin
                x1_next    = rd_x;
                y1_next    = rd_y;
                ram_raddr  = seg_reg + 1'b1;
                state_next = S_HI;
            end
            S_HI: begin
                dx_next    = XW'(rd_x) - XW'(x1_reg);
                dy_next    = XW'(rd_y) - XW'(y1_reg);
                dt_next    = XW'(t_reg) - XW'(x1_reg);
                state_next = S_CHK;
            end
            S_CHK: begin
                if (dx_reg == '0) begin
                    res_val_next = '0;
                    res_sat_next = 1'b0;
                    res_zs_next  = 1'b1;
                    state_next   = S_OUT;
                end else begin
                    md_start   = 1'b1;
                    state_next = S_MD;
                end
            end
            S_MD: begin
                if (md_done) begin
                    res_zs_next = 1'b0;
                    if (md_quo[plin_pkg::PROD_W-1:plin_pkg::QFIT_W] != '0) begin
                        // The quotient alone is beyond any 32-bit result.
                        res_val_next = neg ? plin_pkg::SAT_MIN : plin_pkg::SAT_MAX;
                        res_sat_next = 1'b1;
                    end else if (sum[plin_pkg::SUM_W-1:DW-1]
                                 != {(plin_pkg::SUM_W-DW+1){sum[plin_pkg::SUM_W-1]}}) begin
                        res_val_next = sum[plin_pkg::SUM_W-1] ? plin_pkg::SAT_MIN
                                                              : plin_pkg::SAT_MAX;
                        res_sat_next = 1'b1;
                    end else begin
                        res_val_next = sum[DW-1:0];
                        res_sat_next = 1'b0;
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_val_next   = res_val_reg;
                    m_seg_next   = seg_reg;
                    m_sat_next   = res_sat_reg;
                    m_zs_next    = res_zs_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State, working registers and the output register.
    always_ff @(posedge aclk) begin
        n_reg       <= n_next;
        t_reg       <= t_next;
        x0_reg      <= x0_next;
        asc_reg     <= asc_next;
        scan_reg    <= scan_next;
        seg_reg     <= seg_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        dx_reg      <= dx_next;
        dy_reg      <= dy_next;
        dt_reg      <= dt_next;
        res_val_reg <= res_val_next;
        res_sat_reg <= res_sat_next;
        res_zs_reg  <= res_zs_next;
        m_val_reg   <= m_val_next;
        m_seg_reg   <= m_seg_next;
        m_sat_reg   <= m_sat_next;
        m_zs_reg    <= m_zs_next;
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_interpolated = m_val_reg;
    assign m_segment_low  = plin_pkg::SEG_W'(m_seg_reg);
    assign m_saturated    = m_sat_reg;
    assign m_zero_span    = m_zs_reg;

endmodule

/* hw/rtl/plin_checker.sv */
// Port-level checker of the piecewise-linear interpolator, bound to the top level.
`include "piecewise_linear_interpolator_top_defines.svh"

module plin_checker (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                s_cmd,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [plin_pkg::DATA_W-1:0]  m_interpolated,
    input logic [plin_pkg::SEG_W-1:0]          m_segment_low,
    input logic                                m_saturated,
    input logic                                m_zero_span
);

    // A stalled result holds until its transfer.
    `PLI_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_interpolated) && $stable(m_segment_low) && $stable(m_saturated) && $stable(m_zero_span))

    // A zero-span segment gives zero and never reports a clip.
    `PLI_ASSERT_IMPL(a_zero_span_result, aclk, aresetn, m_valid && m_zero_span, (m_interpolated == '0) && !m_saturated)

    // A clipped result sits at one of the two limits.
    `PLI_ASSERT_IMPL(a_sat_at_limit, aclk, aresetn, m_valid && m_saturated, (m_interpolated == plin_pkg::SAT_MAX) || (m_interpolated == plin_pkg::SAT_MIN))

    // A query occupies the block, so no item is taken in the following cycle.
    `PLI_ASSERT_NEXT(a_busy_after_query, aclk, aresetn, s_valid && s_ready && (s_cmd == plin_pkg::CMD_QUERY), !s_ready)

endmodule

bind piecewise_linear_interpolator_top plin_checker u_plin_checker (.*);

/* sim/piecewise_linear_interpolator_top_tb.sv */
// Self-checking testbench of the piecewise-linear interpolator: directed table, then random phases.
module piecewise_linear_interpolator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import plin_pkg::*;

    localparam int     TABLE_DEPTH     = 8;
    localparam int     NUM_PHASES      = 8;
    localparam int     PHASE_ITEMS     = 97;
    localparam int     SETTLE_CYCLES   = 100;
    localparam int     CYCLE_LIMIT     = 400_000;
    localparam longint Q_MAX           = 2147483647;
    localparam longint Q_MIN           = -Q_MAX - 1;

    // One result of a query, in the order of the result ports.
    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic [SEG_W-1:0]  seg;
        logic              sat;
        logic              zero;
    } interp_res_t;

    // One row of the directed stimulus; known rows carry their result.
    typedef struct packed {
        logic                cmd;
        logic [IDX_IN_W-1:0] idx;
        logic [DATA_W-1:0]   x;
        logic [DATA_W-1:0]   y;
        logic [DATA_W-1:0]   q;
        logic                known;
        interp_res_t         res;
    } directed_row_t;

    localparam interp_res_t NO_RES = '0;

    localparam directed_row_t DIRECTED_ROWS [25] = '{
        // Rising segment from (0, 0.0) to (10, 10.0) at the reset count of two.
        '{CMD_LOAD,  3'd0, 32'd0, 32'h0000_0000, 32'd0, 1'b0, NO_RES},
        '{CMD_LOAD,  3'd1, 32'd10, 32'h000A_0000, 32'd0, 1'b0, NO_RES},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'd5, 1'b1, '{32'h0005_0000, 3'd0, 1'b0, 1'b0}},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'd0, 1'b1, '{32'h0000_0000, 3'd0, 1'b0, 1'b0}},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'd10, 1'b1, '{32'h000A_0000, 3'd0, 1'b0, 1'b0}},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'h8000_0000, 1'b1, '{SAT_MIN, 3'd0, 1'b1, 1'b0}},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1, '{SAT_MAX, 3'd0, 1'b1, 1'b0}},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'hFFFF_FFFD, 1'b0, NO_RES},
        // Equal abscissas give a zero-span result.
        '{CMD_LOAD,  3'd1, 32'd0, 32'h7FFF_FFFF, 32'd0, 1'b0, NO_RES},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'd123, 1'b1, '{32'h0000_0000, 3'd0, 1'b0, 1'b1}},
        // Segment across the whole range of both fields.
        '{CMD_LOAD,  3'd0, 32'h8000_0000, 32'h8000_0000, 32'd0, 1'b0, NO_RES},
        '{CMD_LOAD,  3'd1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd0, 1'b0, NO_RES},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'd0, 1'b0, NO_RES},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'h8000_0000, 1'b1, '{SAT_MIN, 3'd0, 1'b0, 1'b0}},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'h7FFF_FFFF, 1'b1, '{SAT_MAX, 3'd0, 1'b0, 1'b0}},
        // Falling table, queried beyond both ends and inside.
        '{CMD_LOAD,  3'd0, 32'd100, 32'h0064_0000, 32'd0, 1'b0, NO_RES},
        '{CMD_LOAD,  3'd1, 32'hFFFF_FF9C, 32'hFF9C_0000, 32'd0, 1'b0, NO_RES},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'd250, 1'b0, NO_RES},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'hFFFF_FC18, 1'b0, NO_RES},
        '{CMD_QUERY, 3'd0, 32'd0, 32'd0, 32'd7, 1'b0, NO_RES},
        // Fill slots 2 to 6 of the table.
        '{CMD_LOAD,  3'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 1'b0, NO_RES},
        '{CMD_LOAD,  3'd3, 32'd200, 32'h0001_0000, 32'd0, 1'b0, NO_RES},
        '{CMD_LOAD,  3'd4, 32'd300, 32'hFFFE_8000, 32'd0, 1'b0, NO_RES},
        '{CMD_LOAD,  3'd5, 32'd400, 32'h1234_5678, 32'd0, 1'b0, NO_RES},
        '{CMD_LOAD,  3'd6, 32'd500, 32'h8765_4321, 32'd0, 1'b0, NO_RES}
    };

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                cfg_wr_en = 1'b0;
    logic [CFG_W-1:0]    cfg_wr_data = '0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    logic                s_cmd = CMD_LOAD;
    logic [IDX_IN_W-1:0] s_entry_index = '0;
    logic [DATA_W-1:0]   s_abscissa = '0;
    logic [DATA_W-1:0]   s_ordinate = '0;
    logic [DATA_W-1:0]   s_query_point = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    logic [DATA_W-1:0]   m_interpolated;
    logic [SEG_W-1:0]    m_segment_low;
    logic                m_saturated;
    logic                m_zero_span;

    // Mirror of the breakpoint table and the point count.
    int                  bp_x [TABLE_DEPTH];
    int                  bp_y [TABLE_DEPTH];
    logic [CFG_W-1:0]    points_reg = PTS_RESET;

    interp_res_t         pending_results [$];
    int                  max_idle = 4;
    int unsigned         error_count = 0;
    int unsigned         cycle_count = 0;

    piecewise_linear_interpolator_top u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_entry_index  (s_entry_index),
        .s_abscissa     (s_abscissa),
        .s_ordinate     (s_ordinate),
        .s_query_point  (s_query_point),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_interpolated (m_interpolated),
        .m_segment_low  (m_segment_low),
        .m_saturated    (m_saturated),
        .m_zero_span    (m_zero_span)
    );

    // 100 MHz clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The run ends here if results stop coming.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("piecewise_linear_interpolator_top_tb: errors");
            $finish;
        end
    end

    // Point count that queries actually use.
    function automatic int active_points();
        int n;
        n = points_reg;
        if (n < MIN_POINTS) n = MIN_POINTS;
        if (n > TABLE_DEPTH) n = TABLE_DEPTH;
        return n;
    endfunction

    // Segment search, then interpolation with truncation toward zero and saturation.
    function automatic interp_res_t predict_interpolation(input logic [DATA_W-1:0] query);
        int                n, seg, i, tq;
        bit                rising, found, neg;
        longint            t, x1, x2, y1, y2, dx, dy, dt, sum;
        longint unsigned   mag_dx, mag_dy, mag_dt, prod, quot;
        interp_res_t       r;
        n = active_points();
        tq = query;
        t = tq;
        rising = bp_x[1] > bp_x[0];
        seg = n - 2;
        found = 1'b0;
        if (rising) begin
            if (t <= bp_x[0]) begin
                seg = 0;
            end else if (t < bp_x[n-1]) begin
                for (i = 1; i < n; i++) begin
                    if (!found && t < bp_x[i]) begin
                        seg = i - 1;
                        found = 1'b1;
                    end
                end
            end
        end else begin
            if (t >= bp_x[0]) begin
                seg = 0;
            end else if (t > bp_x[n-1]) begin
                for (i = 1; i < n; i++) begin
                    if (!found && t > bp_x[i]) begin
                        seg = i - 1;
                        found = 1'b1;
                    end
                end
            end
        end
        x1 = bp_x[seg];
        x2 = bp_x[seg+1];
        y1 = bp_y[seg];
        y2 = bp_y[seg+1];
        r = '0;
        r.seg = seg[SEG_W-1:0];
        dx = x2 - x1;
        if (dx == 0) begin
            r.zero = 1'b1;
        end else begin
            dy = y2 - y1;
            dt = t - x1;
            mag_dx = (dx < 0) ? -dx : dx;
            mag_dy = (dy < 0) ? -dy : dy;
            mag_dt = (dt < 0) ? -dt : dt;
            prod = mag_dy * mag_dt;
            quot = prod / mag_dx;
            neg = ((dy < 0) != (dt < 0)) != (dx < 0);
            // A quotient this large lands far outside the result range anyway.
            if (quot > 64'h3_FFFF_FFFF) begin
                sum = neg ? Q_MIN - 1 : Q_MAX + 1;
            end else begin
                sum = neg ? y1 - longint'(quot) : y1 + longint'(quot);
            end
            if (sum > Q_MAX) begin
                sum = Q_MAX;
                r.sat = 1'b1;
            end else if (sum < Q_MIN) begin
                sum = Q_MIN;
                r.sat = 1'b1;
            end
            r.value = sum[DATA_W-1:0];
        end
        return r;
    endfunction

    // Abscissa drawn from one of several scales; the small ones give repeated values.
    function automatic int draw_abscissa(input int scale);
        case (scale)
            0: return int'($urandom_range(0, 40)) - 20;
            1: return int'($urandom_range(0, 200000)) - 100000;
            2: return $urandom;
            default: begin
                case ($urandom_range(0, 4))
                    0: return int'(SAT_MIN);
                    1: return int'(SAT_MAX);
                    2: return 0;
                    3: return -1;
                    default: return $urandom;
                endcase
            end
        endcase
    endfunction

    // Q16.16 ordinate, either modest or spread over the full word.
    function automatic int draw_ordinate();
        if ($urandom_range(0, 1) == 0) begin
            return $urandom;
        end
        return ((int'($urandom_range(0, 200)) - 100) <<< 16) | int'($urandom_range(0, 65535));
    endfunction

    // Query point near a breakpoint, inside a segment, at an extreme, or anywhere.
    function automatic logic [DATA_W-1:0] draw_query_point();
        int     n, k, sel, frac;
        longint a, b, v;
        n = active_points();
        sel = $urandom_range(0, 9);
        v = 0;
        if (sel < 3) begin
            k = $urandom_range(0, n - 1);
            v = longint'(bp_x[k]) + (int'($urandom_range(0, 4)) - 2);
        end else if (sel < 7) begin
            k = $urandom_range(0, n - 2);
            frac = $urandom_range(0, 16);
            a = bp_x[k];
            b = bp_x[k+1];
            v = a + ((b - a) * frac) / 16;
        end else if (sel == 7) begin
            v = draw_abscissa(3);
        end else begin
            v = $urandom;
        end
        return v[DATA_W-1:0];
    endfunction

    // Present one item, wait for its transfer, and record what it should produce.
    task automatic send_item(input logic cmd, input logic [IDX_IN_W-1:0] idx,
                             input logic [DATA_W-1:0] x, input logic [DATA_W-1:0] y,
                             input logic [DATA_W-1:0] q, input logic known,
                             input interp_res_t known_res);
        int gap;
        gap = (max_idle == 0) ? 0 : $urandom_range(0, max_idle);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_cmd         <= cmd;
        s_entry_index <= idx;
        s_abscissa    <= x;
        s_ordinate    <= y;
        s_query_point <= q;
        do @(posedge aclk); while (!s_ready);
        if (cmd == CMD_LOAD) begin
            bp_x[idx] = x;
            bp_y[idx] = y;
        end else begin
            pending_results.push_back(known ? known_res : predict_interpolation(q));
        end
    endtask

    // Hold the input side until every result is in and the block has gone quiet.
    task automatic settle_idle();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_points(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        points_reg = value;
        cfg_wr_en <= 1'b0;
    endtask

    // Reload the whole table as a sorted run, rising or falling, sometimes with one bad entry.
    task automatic load_table();
        int  xs [TABLE_DEPTH];
        int  i, j, tmp, scale, slot;
        bit  falling, backward;
        scale = $urandom_range(0, 3);
        falling = $urandom_range(0, 1);
        backward = $urandom_range(0, 1);
        for (i = 0; i < TABLE_DEPTH; i++) xs[i] = draw_abscissa(scale);
        for (i = 0; i < TABLE_DEPTH - 1; i++) begin
            for (j = 0; j < TABLE_DEPTH - 1 - i; j++) begin
                if (xs[j] > xs[j+1]) begin
                    tmp = xs[j];
                    xs[j] = xs[j+1];
                    xs[j+1] = tmp;
                end
            end
        end
        if ($urandom_range(0, 3) == 0) xs[$urandom_range(0, TABLE_DEPTH - 1)] = $urandom;
        for (i = 0; i < TABLE_DEPTH; i++) begin
            slot = backward ? TABLE_DEPTH - 1 - i : i;
            send_item(CMD_LOAD, slot[IDX_IN_W-1:0],
                      xs[falling ? TABLE_DEPTH - 1 - slot : slot],
                      draw_ordinate(), $urandom, 1'b0, NO_RES);
        end
    endtask

    // Result side: random stalls, then compare each transfer with the oldest expectation.
    initial begin
        int          gap;
        interp_res_t want;
        wait (aresetn);
        forever begin
            gap = (max_idle == 0) ? 0 : $urandom_range(0, max_idle);
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            if (pending_results.size() == 0) begin
                $error("result transfer with no query outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_interpolated !== want.value) begin
                    $error("interpolated: expected %h, actual %h", want.value, m_interpolated);
                    error_count++;
                end
                if (m_segment_low !== want.seg) begin
                    $error("segment_low: expected %0d, actual %0d", want.seg, m_segment_low);
                    error_count++;
                end
                if (m_saturated !== want.sat) begin
                    $error("saturated: expected %b, actual %b", want.sat, m_saturated);
                    error_count++;
                end
                if (m_zero_span !== want.zero) begin
                    $error("zero_span: expected %b, actual %b", want.zero, m_zero_span);
                    error_count++;
                end
            end
        end
    end

    // Reset, directed rows, then random phases at several point counts.
    initial begin
        logic [CFG_W-1:0] phase_points [NUM_PHASES];
        logic [CFG_W-1:0] cfg;
        int               ph, k, idx;
        phase_points = '{4'd0, 4'd15, 4'd8, 4'd1, 4'd5, 4'd2, 4'd0, 4'd9};
        for (k = 0; k < TABLE_DEPTH; k++) begin
            bp_x[k] = 0;
            bp_y[k] = 0;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        for (k = 0; k < $size(DIRECTED_ROWS); k++) begin
            send_item(DIRECTED_ROWS[k].cmd, DIRECTED_ROWS[k].idx, DIRECTED_ROWS[k].x,
                      DIRECTED_ROWS[k].y, DIRECTED_ROWS[k].q, DIRECTED_ROWS[k].known,
                      DIRECTED_ROWS[k].res);
        end
        // The last table slot has not been written yet.
        send_item(CMD_LOAD, 3'd7, 32'd600, 32'h0000_8000, 32'd0, 1'b0, NO_RES);

        for (ph = 0; ph < NUM_PHASES; ph++) begin
            settle_idle();
            cfg = (ph == 6) ? CFG_W'($urandom_range(3, 14)) : phase_points[ph];
            write_points(cfg);
            max_idle = (ph % 3 == 2) ? 0 : 4;
            load_table();
            for (k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 4) == 0) begin
                    // Stray load that may break the ordering of the table.
                    idx = $urandom_range(0, TABLE_DEPTH - 1);
                    send_item(CMD_LOAD, idx[IDX_IN_W-1:0], draw_abscissa($urandom_range(0, 3)),
                              draw_ordinate(), $urandom, 1'b0, NO_RES);
                end else begin
                    send_item(CMD_QUERY, 3'($urandom), $urandom, $urandom,
                              draw_query_point(), 1'b0, NO_RES);
                end
            end
        end

        settle_idle();
        if (error_count == 0) begin
            $display("piecewise_linear_interpolator_top_tb: clean");
        end else begin
            $display("piecewise_linear_interpolator_top_tb: errors");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/plin_pkg.sv
hw/rtl/plin_ram.sv
hw/rtl/plin_muldiv.sv
hw/rtl/piecewise_linear_interpolator_top.sv
hw/rtl/plin_checker.sv
sim/piecewise_linear_interpolator_top_tb.sv
